[hdl/npc_pkg.sv]
// shared constants, types and helpers of the nearest palette color mapper
// no dependencies
package npc_pkg;

  localparam int PaletteSize = 16;
  localparam int IdxW        = (PaletteSize > 1) ? $clog2(PaletteSize) : 1;
  localparam int TreeSize    = 1 << IdxW;
  localparam int ChanW       = 8;
  localparam int NumChan     = 3;
  localparam int RgbW        = NumChan * ChanW;
  localparam int SlotW       = 4;
  localparam int IndexW      = 4;
  localparam int DistW       = 10;

  // larger than any real distance (max 765), used for unused tree leaves
  localparam logic [DistW-1:0] DistStart = 10'h3FF;

  typedef logic [RgbW-1:0]  rgb_t;
  typedef logic [ChanW-1:0] chan_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef enum logic {
    ReqMap  = 1'b0,
    ReqLoad = 1'b1
  } npc_req_e;

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[hdl/npc_if.sv]
// valid/ready channel interfaces for the request and response sides
// depends on npc_pkg
interface npc_req_if;
  import npc_pkg::*;

  logic                   valid;
  logic                   ready;
  npc_req_e               req_type;
  logic [SlotW-1:0]       entry_slot;
  rgb_t                   rgb_value;

  modport source (output valid, req_type, entry_slot, rgb_value, input ready);
  modport sink   (input valid, req_type, entry_slot, rgb_value, output ready);
endinterface

interface npc_rsp_if;
  import npc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [IndexW-1:0]      palette_index;

  modport source (output valid, palette_index, input ready);
  modport sink   (input valid, palette_index, output ready);
endinterface

[hdl/npc_min_tree.sv]
// pipelined minimum tree over the per-entry distances, one register per level
// depends on npc_pkg
module npc_min_tree (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  npc_pkg::dist_t dist_i [npc_pkg::PaletteSize],
  output logic           vld_o,
  output npc_pkg::idx_t  idx_o
);
  import npc_pkg::*;

  dist_t            leaf_dist [TreeSize];
  idx_t             leaf_idx  [TreeSize];
  dist_t            node_dist_q [1:TreeSize-1];
  idx_t             node_idx_q  [1:TreeSize-1];
  logic [IdxW-1:0]  vld_q;

  for (genvar k = 0; k < TreeSize; k++) begin : g_leaf
    if (k < PaletteSize) begin : g_used
      assign leaf_dist[k] = dist_i[k];
    end else begin : g_pad
      assign leaf_dist[k] = DistStart;
    end
    assign leaf_idx[k] = IdxW'(k);
  end

  // heap layout: node n takes children 2n and 2n+1, the left one wins a tie
  for (genvar n = 1; n < TreeSize; n++) begin : g_node
    dist_t l_dist, r_dist;
    idx_t  l_idx, r_idx;

    if (2 * n >= TreeSize) begin : g_from_leaf
      assign l_dist = leaf_dist[2*n-TreeSize];
      assign l_idx  = leaf_idx[2*n-TreeSize];
      assign r_dist = leaf_dist[2*n+1-TreeSize];
      assign r_idx  = leaf_idx[2*n+1-TreeSize];
    end else begin : g_from_node
      assign l_dist = node_dist_q[2*n];
      assign l_idx  = node_idx_q[2*n];
      assign r_dist = node_dist_q[2*n+1];
      assign r_idx  = node_idx_q[2*n+1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r_dist < l_dist) begin
          node_dist_q[n] <= r_dist;
          node_idx_q[n]  <= r_idx;
        end else begin
          node_dist_q[n] <= l_dist;
          node_idx_q[n]  <= l_idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= IdxW'({vld_q, vld_i});
    end
  end

  assign vld_o = vld_q[IdxW-1];
  assign idx_o = node_idx_q[1];

endmodule

[hdl/nearest_palette_color_mapper_unit.sv]
// Nearest palette color mapper. Each request transaction either loads one
// palette entry (no response) or maps a 24-bit pixel to the index of the
// palette color with the smallest sum of absolute channel differences, the
// lowest index winning a tie. The palette resets to all zero. A pixel is
// taken every clock unless the response side stalls, and passes one stage
// of channel differences, one stage of distance sums, then one stage per
// level of the comparator tree. Loads are also taken one per clock on the
// same terms and affect every pixel accepted after them. When the response
// side stalls the whole pipeline holds and request ready drops.
// depends on npc_pkg, npc_if and npc_min_tree
module nearest_palette_color_mapper_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  npc_req_if.sink    req_i,
  npc_rsp_if.source  rsp_o
);
  import npc_pkg::*;

  // palette storage, read by every lane in parallel
  rgb_t   palette_q [PaletteSize];

  // pipeline registers
  logic   s1_vld_q;
  chan_t  diff_q [PaletteSize][NumChan];
  logic   s2_vld_q;
  dist_t  dist_q [PaletteSize];

  logic   en;
  logic   req_fire, pix_fire, load_fire;
  logic   slot_ok;
  idx_t   slot_idx;
  logic   rsp_vld;
  idx_t   best_idx;

  // global advance: the tree root is the output register
  assign en          = !rsp_vld || rsp_o.ready;
  assign req_i.ready = en;

  assign req_fire  = req_i.valid && en;
  assign pix_fire  = req_fire && (req_i.req_type == ReqMap);
  assign load_fire = req_fire && (req_i.req_type == ReqLoad);
  // loads to slots beyond the palette are dropped
  assign slot_ok   = (32'(req_i.entry_slot) < PaletteSize);
  assign slot_idx  = IdxW'(req_i.entry_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PaletteSize; k++) begin
        palette_q[k] <= '0;
      end
    end else if (load_fire && slot_ok) begin
      palette_q[slot_idx] <= req_i.rgb_value;
    end
  end

  // valid bits of the first two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= pix_fire;
      s2_vld_q <= s1_vld_q;
    end
  end

  // stage 1: per-channel absolute differences against the palette as it
  // stands before this edge, so a load in the same cycle is not seen
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < PaletteSize; k++) begin
        for (int c = 0; c < NumChan; c++) begin
          diff_q[k][c] <= abs_diff(req_i.rgb_value[c*ChanW +: ChanW],
                                   palette_q[k][c*ChanW +: ChanW]);
        end
      end
    end
  end

  // stage 2: L1 distance per palette entry
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < PaletteSize; k++) begin
        dist_q[k] <= DistW'(diff_q[k][0]) + DistW'(diff_q[k][1]) + DistW'(diff_q[k][2]);
      end
    end
  end

  // remaining stages: comparator tree down to the winning index
  npc_min_tree u_min_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s2_vld_q),
    .dist_i (dist_q),
    .vld_o  (rsp_vld),
    .idx_o  (best_idx)
  );

  assign rsp_o.valid         = rsp_vld;
  assign rsp_o.palette_index = IndexW'(best_idx);

  // a load lands in its palette slot
  a_load_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_fire && slot_ok) |=> palette_q[$past(slot_idx)] == $past(req_i.rgb_value))
    else $error("palette load not stored");

  // a load never creates a pipeline transaction
  a_load_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> !s1_vld_q)
    else $error("load entered the pipeline");

  // a pixel always enters the first stage
  a_pix_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire |=> s1_vld_q)
    else $error("pixel lost at pipeline entry");

  // a stalled second stage keeps its transaction
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !en) |=> s2_vld_q)
    else $error("transaction lost during stall");

endmodule
